// File: src/lcdf_pkg.sv
// ----------------------------------------------------------------------------
// lcdf_pkg
// Shared types and constants for the LCD decimal field formatter: request and
// result beats, the work entry passed from front to back, and character codes.
// ----------------------------------------------------------------------------
package lcdf_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;

  localparam logic [3:0] MAX_DIGITS = 4'd5;

  localparam logic [7:0] CMD_HOME   = 8'h80;
  localparam logic [7:0] ROW1_BASE  = 8'h80;
  localparam logic [7:0] ROW2_BASE  = 8'hC0;
  localparam logic [7:0] ROW3_BASE  = 8'h94;
  localparam logic [7:0] ROW4_BASE  = 8'hD4;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] CHAR_ERR   = 8'h45;

  typedef struct packed {
    logic [2:0]  row;
    logic [6:0]  column;
    logic [15:0] value;
    logic [3:0]  digits;
  } request_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } result_t;

  // One classified request, ready for the byte sequencer.
  typedef struct packed {
    logic             has_cmd;
    logic [7:0]       cmd;
    logic             err;
    logic [2:0]       ndig;
    logic [BCD_W-1:0] bcd;
  } work_t;

endpackage

// File: src/lcdf_front.sv
// ----------------------------------------------------------------------------
// lcdf_front
// Accepts requests, works out the cursor command and digit mode, and converts
// the value to BCD over two pipeline steps of eight shift-add-3 stages each.
// ----------------------------------------------------------------------------
module lcdf_front
  import lcdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     q_push,
  output work_t    q_data,
  input  logic     q_full
);

  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  logic             accept;
  logic             has_cmd;
  logic [7:0]       cmd;
  logic [7:0]       row_base;
  logic             err;
  logic [2:0]       ndig;
  logic [BCD_W-1:0] bcd_hi;
  logic [BCD_W-1:0] bcd_full;

  logic             s1_valid;
  logic             s1_has_cmd;
  logic [7:0]       s1_cmd;
  logic             s1_err;
  logic [2:0]       s1_ndig;
  logic [11:0]      s1_bcd;
  logic [7:0]       s1_low;

  assign full   = s1_valid && q_full;
  assign accept = push && !full;
  assign q_push = s1_valid && !q_full;

  always_comb begin
    unique case (request.row)
      3'd2:    row_base = ROW2_BASE;
      3'd3:    row_base = ROW3_BASE;
      3'd4:    row_base = ROW4_BASE;
      default: row_base = ROW1_BASE;
    endcase
  end

  always_comb begin
    has_cmd = 1'b1;
    cmd     = CMD_HOME;
    if (request.row == 3'd0 || request.column == 7'd0) begin
      cmd = CMD_HOME;
    end else if (request.row <= 3'd4) begin
      cmd = row_base + {1'b0, request.column} - 8'd1;
    end else begin
      has_cmd = 1'b0;
    end
    err  = request.digits > MAX_DIGITS;
    ndig = err ? 3'd0 : request.digits[2:0];
  end

  // The high byte goes through the first eight conversion stages.
  always_comb begin
    bcd_hi = '0;
    for (int i = 7; i >= 0; i--) begin
      bcd_hi = dd_step(bcd_hi, request.value[8 + i]);
    end
  end

  always_comb begin
    bcd_full = {8'd0, s1_bcd};
    for (int i = 7; i >= 0; i--) begin
      bcd_full = dd_step(bcd_full, s1_low[i]);
    end
  end

  assign q_data = '{has_cmd: s1_has_cmd, cmd: s1_cmd, err: s1_err, ndig: s1_ndig,
                    bcd: bcd_full};

  // A request that yields no bytes is dropped here and never enters the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= has_cmd || err || (ndig != 3'd0);
    end else if (q_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_has_cmd <= has_cmd;
      s1_cmd     <= cmd;
      s1_err     <= err;
      s1_ndig    <= ndig;
      s1_bcd     <= bcd_hi[11:0];
      s1_low     <= request.value[7:0];
    end
  end

endmodule

// File: src/lcdf_queue.sv
// ----------------------------------------------------------------------------
// lcdf_queue
// Small first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module lcdf_queue
  import lcdf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output work_t pop_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  work_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == FULL_CNT;
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/lcdf_back.sv
// ----------------------------------------------------------------------------
// lcdf_back
// Byte sequencer: while pop keeps up, walks the head work entry one byte per
// cycle into the result register; releases the entry with its last byte.
// ----------------------------------------------------------------------------
module lcdf_back
  import lcdf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  work_t   q_data,
  output logic    q_pop,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic       out_valid;
  logic [2:0] cnt;
  logic [2:0] total;
  logic [2:0] pos;
  logic [3:0] nib;
  logic       load;
  logic       is_last;
  result_t    next_beat;

  assign empty   = !out_valid;
  assign load    = !q_empty && (!out_valid || pop);
  assign total   = {2'b00, q_data.has_cmd} + (q_data.err ? 3'd1 : q_data.ndig);
  assign is_last = cnt == (total - 3'd1);
  assign q_pop   = load && is_last;

  // Digit position counted from the ones digit.
  assign pos = q_data.ndig - 3'd1 - (cnt - {2'b00, q_data.has_cmd});

  always_comb begin
    case (pos)
      3'd0:    nib = q_data.bcd[3:0];
      3'd1:    nib = q_data.bcd[7:4];
      3'd2:    nib = q_data.bcd[11:8];
      3'd3:    nib = q_data.bcd[15:12];
      3'd4:    nib = q_data.bcd[19:16];
      default: nib = 4'd0;
    endcase
  end

  always_comb begin
    next_beat.last = is_last;
    if (q_data.has_cmd && cnt == 3'd0) begin
      next_beat.lcd_byte = q_data.cmd;
      next_beat.is_data  = 1'b0;
    end else if (q_data.err) begin
      next_beat.lcd_byte = CHAR_ERR;
      next_beat.is_data  = 1'b1;
    end else begin
      next_beat.lcd_byte = ASCII_ZERO + {4'd0, nib};
      next_beat.is_data  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 3'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cnt       <= is_last ? 3'd0 : cnt + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_beat;
    end
  end

endmodule

// File: src/lcd_decimal_field_formatter_unit.sv
// ----------------------------------------------------------------------------
// lcd_decimal_field_formatter_unit
// Turns print requests into a character-LCD byte stream: an optional cursor
// command followed by decimal digits, or the letter E for a bad digit count.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on push/full with the request struct; a request beat is
// taken when push is high and full is low. Results leave on empty/pop: the
// oldest byte sits on result while empty is low and is taken when pop is high.
// Each request gives zero to six result beats; the final one carries last.
// A request that gives no bytes is absorbed and produces nothing.
// The first byte of a request passes the front register, a queue entry and the
// result register when nothing is queued ahead of it. The result port moves
// one byte per cycle while pop keeps up; a request gives six bytes at most
// (cursor plus five digits). The front takes a new request every cycle while
// the queue has room. A stall on pop holds the result register; the work
// queue then fills and full rises, after which requests wait at the input. A
// synchronous reset empties the pipeline, the queue and the result register.
// ----------------------------------------------------------------------------
module lcd_decimal_field_formatter_unit
  import lcdf_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  work_t q_in;
  work_t q_out;

  lcdf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .request (request),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_full  (q_full)
  );

  lcdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  lcdf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // Releasing a queue entry means its final byte was just loaded for output.
  a_pop_on_last : assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (!empty && result.last))
    else $error("queue entry released without a last byte");

  a_queue_state : assert property (@(posedge clk) disable iff (rst)
    !(q_empty && q_full))
    else $error("work queue reports empty and full together");

  a_data_char : assert property (@(posedge clk) disable iff (rst)
    (!empty && result.is_data) |->
      ((result.lcd_byte == CHAR_ERR) ||
       (result.lcd_byte >= ASCII_ZERO && result.lcd_byte <= ASCII_ZERO + 8'd9)))
    else $error("character beat is neither a digit nor the error letter");

endmodule
